// File: hdl/rrip_ship_stream_replacement_top_assert.svh
`ifndef RRIP_SHIP_STREAM_REPLACEMENT_TOP_ASSERT_SVH
`define RRIP_SHIP_STREAM_REPLACEMENT_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
`define RRIP_SS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RRIP_SS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RRIP_SS_ASSERT(lbl, prop, msg)
`define RRIP_SS_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// File: hdl/rrip_ss_pkg.sv
package rrip_ss_pkg;

  typedef struct packed {
    logic        req_type;
    logic [10:0] set_index;
    logic [3:0]  way_index;
    logic        was_hit;
    logic [63:0] phys_addr;
    logic [4:0]  pc_bits;
  } in_item_t;

  typedef struct packed {
    logic [3:0] victim_way;
    logic [1:0] insert_rrpv;
    logic       streaming;
  } out_item_t;

  typedef struct packed {
    logic [63:0] addr;
    logic [63:0] delta;
    logic [1:0]  cnt;
  } stride_ent_t;

  typedef stride_ent_t [1:0] stride_row_t;

  typedef struct packed {
    logic        streaming;
    stride_row_t row;
  } stride_res_t;

  localparam logic       REQ_VICTIM  = 1'b0;
  localparam logic       REG_THR     = 1'b0;
  localparam logic       REG_LEADER  = 1'b1;
  localparam logic [1:0] THR_RST     = 2'd3;
  localparam logic [6:0] LEADER_RST  = 7'd32;
  localparam logic [9:0] SEL_INIT    = 10'd512;
  localparam logic [9:0] SEL_MAX     = 10'd1023;
  localparam logic [15:0] LFSR_SEED  = 16'hACE1;
  localparam logic [1:0] RRPV_MAX    = 2'd3;
  localparam logic [1:0] RRPV_LONG   = 2'd2;
  localparam logic [1:0] RRPV_NEAR   = 2'd1;
  localparam logic [1:0] CNT_MAX     = 2'd3;
  localparam logic [1:0] DEAD_LIMIT  = 2'd2;
  localparam logic [1:0] SO_TRUST    = 2'd2;
  localparam int         LINE_SHIFT  = 6;

endpackage

// File: hdl/rrip_ss_ram.sv
module rrip_ss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/rrip_ss_stride.sv
module rrip_ss_stride
  import rrip_ss_pkg::*;
(
  input  stride_row_t cur,
  input  logic [63:0] addr,
  input  logic [1:0]  thr,
  output stride_res_t res
);

  always_comb begin
    logic [63:0] d0;
    logic [63:0] d1;
    logic        m0;
    logic        m1;
    logic [1:0]  c;
    d0 = addr - cur[0].addr;
    d1 = addr - cur[1].addr;
    m0 = (cur[0].delta != '0) && (d0 == cur[0].delta);
    m1 = (cur[1].delta != '0) && (d1 == cur[1].delta);
    c = '0;
    res.row = cur;
    res.streaming = 1'b0;
    if (m0) begin
      c = (cur[0].cnt == CNT_MAX) ? CNT_MAX : cur[0].cnt + 2'd1;
      res.row[0].cnt = c;
      res.row[0].addr = addr;
      res.streaming = (c >= thr);
    end else if (m1) begin
      c = (cur[1].cnt == CNT_MAX) ? CNT_MAX : cur[1].cnt + 2'd1;
      res.row[1].cnt = c;
      res.row[1].addr = addr;
      res.streaming = (c >= thr);
    end else if (cur[0].addr <= cur[1].addr) begin
      res.row[0].delta = d0;
      res.row[0].addr = addr;
      res.row[0].cnt = 2'd1;
    end else begin
      res.row[1].delta = d1;
      res.row[1].addr = addr;
      res.row[1].cnt = 2'd1;
    end
  end

endmodule

// File: hdl/rrip_ship_stream_replacement_top.sv
// Flow: the accepting edge reads the set's rows into the RAM output registers; the execute
//   state then computes, writes back and loads the result register, waiting there while
//   out_stall holds a pending result. A fill inserted at distance 3 adds the ST_DEC state
//   for the signature counter write. A new request is taken only once back in idle.
// A fill that ends a stride-clear or dead-decay period adds a sweep over every set. Reset
//   (synchronous, rst_n low) starts a clear pass over the memories; in_stall stays high until it ends.
`include "rrip_ship_stream_replacement_top_assert.svh"

module rrip_ship_stream_replacement_top
  import rrip_ss_pkg::*;
#(
  parameter int NUM_SETS            = 2048,
  parameter int NUM_WAYS            = 16,
  parameter int SIG_BITS            = 5,
  parameter int STREAM_CLEAR_PERIOD = 4096,
  parameter int DEAD_DECAY_PERIOD   = 8192
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int SET_W     = $clog2(NUM_SETS);
  localparam int WAY_W     = $clog2(NUM_WAYS);
  localparam int SIG_COUNT = 1 << SIG_BITS;
  localparam int ROW_W     = NUM_WAYS * (4 + SIG_BITS);
  localparam int CLR_LEN   = (NUM_SETS > SIG_COUNT) ? NUM_SETS : SIG_COUNT;
  localparam int PTR_W     = $clog2(CLR_LEN + 1);
  localparam int SCP_W     = $clog2(STREAM_CLEAR_PERIOD);
  localparam int DDP_W     = $clog2(DEAD_DECAY_PERIOD);
  localparam int CW        = SET_W + 8;
  localparam int STR_W     = $bits(stride_row_t);

  localparam logic [2:0] ST_CLR   = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_EXEC  = 3'd2;
  localparam logic [2:0] ST_DEC   = 3'd3;
  localparam logic [2:0] ST_SWEEP = 3'd4;

  logic [2:0]          state_r, state_nxt;
  logic [PTR_W-1:0]    ptr_r, ptr_nxt;
  logic                swp_wv_r, swp_wv_nxt;
  logic [SET_W-1:0]    swp_wa_r, swp_wa_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_data_r, out_data_nxt;
  logic [9:0]          sel_r, sel_nxt;
  logic [15:0]         lfsr_r, lfsr_nxt;
  logic [1:0]          thr_r;
  logic [6:0]          leader_r;
  logic [SCP_W-1:0]    fcs_r, fcs_nxt;
  logic [DDP_W-1:0]    fcd_r, fcd_nxt;
  logic                sclr_r, sclr_nxt;
  logic                decay_r, decay_nxt;

  logic                type_r;
  logic                hit_r;
  logic [SET_W-1:0]    set_r;
  logic [WAY_W-1:0]    way_r;
  logic [SIG_BITS-1:0] sig_r;
  logic [63:0]         addr_r;
  logic [SIG_BITS-1:0] dsig_r, dsig_nxt;

  logic                acc;
  logic [63:0]         sig_x;
  logic [SIG_BITS-1:0] sig_in;

  logic                row_we, row_re;
  logic [SET_W-1:0]    row_waddr, row_raddr;
  logic [ROW_W-1:0]    row_wdata, row_rdata;
  logic                str_we;
  stride_row_t         str_wdata, str_rdata;
  logic                so_we, so_re;
  logic [SIG_BITS-1:0] so_waddr, so_raddr;
  logic [1:0]          so_wdata, so_rdata;

  logic [NUM_WAYS-1:0][1:0]          rd_rrpv, rd_dead, wr_rrpv, wr_dead;
  logic [NUM_WAYS-1:0][SIG_BITS-1:0] rd_sig, wr_sig;

  stride_res_t         str_res;

  assign {rd_dead, rd_sig, rd_rrpv} = row_rdata;
  assign row_wdata = {wr_dead, wr_sig, wr_rrpv};

  assign acc      = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign sig_x    = 64'(in_data.pc_bits) ^ (in_data.phys_addr >> LINE_SHIFT);
  assign sig_in   = sig_x[SIG_BITS-1:0];

  rrip_ss_ram #(.WIDTH(ROW_W), .DEPTH(NUM_SETS)) u_row_ram (
    .clk  (clk),
    .we   (row_we),
    .waddr(row_waddr),
    .wdata(row_wdata),
    .re   (row_re),
    .raddr(row_raddr),
    .rdata(row_rdata)
  );

  rrip_ss_ram #(.WIDTH(STR_W), .DEPTH(NUM_SETS)) u_str_ram (
    .clk  (clk),
    .we   (str_we),
    .waddr(row_waddr),
    .wdata(str_wdata),
    .re   (row_re),
    .raddr(row_raddr),
    .rdata(str_rdata)
  );

  rrip_ss_ram #(.WIDTH(2), .DEPTH(SIG_COUNT)) u_so_ram (
    .clk  (clk),
    .we   (so_we),
    .waddr(so_waddr),
    .wdata(so_wdata),
    .re   (so_re),
    .raddr(so_raddr),
    .rdata(so_rdata)
  );

  rrip_ss_stride u_stride (
    .cur (str_rdata),
    .addr(addr_r),
    .thr (thr_r),
    .res (str_res)
  );

  always_comb begin
    logic [CW-1:0]    set_w;
    logic [CW-1:0]    lead_w;
    logic             lead_s;
    logic             lead_b;
    logic             brrip;
    logic             go;
    logic             any3;
    logic             any2;
    logic             any1;
    logic [1:0]       top;
    logic [WAY_W-1:0] vi;
    logic [15:0]      lfsr_step;
    logic [1:0]       ins;
    logic             wrap_s;
    logic             wrap_d;

    set_w  = CW'(set_r);
    lead_w = CW'(leader_r);
    lead_s = set_w < lead_w;
    lead_b = (set_w + lead_w) >= CW'(NUM_SETS);
    brrip  = !(lead_s || (!lead_b && sel_r >= SEL_INIT));
    go     = !out_valid_r || !out_stall;

    any3 = 1'b0;
    any2 = 1'b0;
    any1 = 1'b0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      any3 = any3 | (rd_rrpv[w] == 2'd3);
      any2 = any2 | (rd_rrpv[w] == 2'd2);
      any1 = any1 | (rd_rrpv[w] == 2'd1);
    end
    top = any3 ? 2'd3 : any2 ? 2'd2 : any1 ? 2'd1 : 2'd0;
    vi = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (rd_rrpv[w] == top) vi = WAY_W'(w);
    end

    lfsr_step = {lfsr_r[0] ^ lfsr_r[2] ^ lfsr_r[3] ^ lfsr_r[5], lfsr_r[15:1]};
    ins = RRPV_LONG;
    if (brrip) ins = (lfsr_step[4:0] == 5'd0) ? RRPV_NEAR : RRPV_LONG;
    if (str_res.streaming) ins = RRPV_MAX;
    else if (so_rdata >= SO_TRUST) ins = 2'd0;
    else if (so_rdata == 2'd0) ins = RRPV_LONG;
    if (rd_dead[way_r] >= DEAD_LIMIT) ins = RRPV_MAX;

    wrap_s = (fcs_r == SCP_W'(STREAM_CLEAR_PERIOD - 1));
    wrap_d = (fcd_r == DDP_W'(DEAD_DECAY_PERIOD - 1));

    state_nxt     = state_r;
    ptr_nxt       = ptr_r;
    swp_wv_nxt    = 1'b0;
    swp_wa_nxt    = swp_wa_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    sel_nxt       = sel_r;
    lfsr_nxt      = lfsr_r;
    fcs_nxt       = fcs_r;
    fcd_nxt       = fcd_r;
    sclr_nxt      = sclr_r;
    decay_nxt     = decay_r;
    dsig_nxt      = dsig_r;

    row_we    = 1'b0;
    str_we    = 1'b0;
    row_re    = 1'b0;
    row_waddr = set_r;
    row_raddr = SET_W'(in_data.set_index);
    wr_rrpv   = rd_rrpv;
    wr_sig    = rd_sig;
    wr_dead   = rd_dead;
    str_wdata = str_res.row;
    so_we     = 1'b0;
    so_re     = 1'b0;
    so_waddr  = sig_r;
    so_wdata  = '0;
    so_raddr  = sig_in;

    case (state_r)
      ST_CLR: begin
        row_we    = ptr_r < PTR_W'(NUM_SETS);
        str_we    = row_we;
        row_waddr = ptr_r[SET_W-1:0];
        wr_rrpv   = {NUM_WAYS{RRPV_MAX}};
        wr_sig    = '0;
        wr_dead   = '0;
        str_wdata = '0;
        so_we     = ptr_r < PTR_W'(SIG_COUNT);
        so_waddr  = ptr_r[SIG_BITS-1:0];
        ptr_nxt   = ptr_r + PTR_W'(1);
        if (ptr_r == PTR_W'(CLR_LEN - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        row_re = acc;
        so_re  = acc;
        if (acc) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (go) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          row_we        = 1'b1;
          state_nxt     = ST_IDLE;
          if (type_r == REQ_VICTIM) begin
            for (int w = 0; w < NUM_WAYS; w++) begin
              wr_rrpv[w] = rd_rrpv[w] + (RRPV_MAX - top);
            end
            out_data_nxt.victim_way = 4'(vi);
          end else if (hit_r) begin
            wr_rrpv[way_r] = 2'd0;
            wr_sig[way_r]  = sig_r;
            wr_dead[way_r] = 2'd0;
            so_we    = 1'b1;
            so_wdata = (so_rdata == CNT_MAX) ? CNT_MAX : so_rdata + 2'd1;
            if (lead_s) begin
              if (sel_r != SEL_MAX) sel_nxt = sel_r + 10'd1;
            end else if (lead_b) begin
              if (sel_r != 10'd0) sel_nxt = sel_r - 10'd1;
            end
          end else begin
            wr_rrpv[way_r] = ins;
            wr_sig[way_r]  = sig_r;
            wr_dead[way_r] = 2'd1;
            str_we = 1'b1;
            if (brrip) lfsr_nxt = lfsr_step;
            out_data_nxt.insert_rrpv = ins;
            out_data_nxt.streaming   = str_res.streaming;
            fcs_nxt   = wrap_s ? '0 : fcs_r + SCP_W'(1);
            fcd_nxt   = wrap_d ? '0 : fcd_r + DDP_W'(1);
            sclr_nxt  = wrap_s;
            decay_nxt = wrap_d;
            ptr_nxt   = '0;
            if (ins == RRPV_MAX) begin
              so_re     = 1'b1;
              so_raddr  = rd_sig[way_r];
              dsig_nxt  = rd_sig[way_r];
              state_nxt = ST_DEC;
            end else if (wrap_s || wrap_d) begin
              state_nxt = ST_SWEEP;
            end
          end
        end
      end
      ST_DEC: begin
        so_waddr = dsig_r;
        so_we    = (so_rdata != 2'd0);
        so_wdata = so_rdata - 2'd1;
        state_nxt = (sclr_r || decay_r) ? ST_SWEEP : ST_IDLE;
      end
      ST_SWEEP: begin
        row_raddr = ptr_r[SET_W-1:0];
        if (ptr_r < PTR_W'(NUM_SETS)) begin
          row_re     = 1'b1;
          ptr_nxt    = ptr_r + PTR_W'(1);
          swp_wv_nxt = 1'b1;
          swp_wa_nxt = ptr_r[SET_W-1:0];
        end
        row_waddr = swp_wa_r;
        row_we    = swp_wv_r;
        str_we    = swp_wv_r;
        str_wdata = str_rdata;
        if (sclr_r) begin
          str_wdata[0].cnt = 2'd0;
          str_wdata[1].cnt = 2'd0;
        end
        if (decay_r) begin
          for (int w = 0; w < NUM_WAYS; w++) begin
            if (rd_dead[w] != 2'd0) wr_dead[w] = rd_dead[w] - 2'd1;
          end
        end
        if (ptr_r == PTR_W'(NUM_SETS) && !swp_wv_r) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_CLR;
        ptr_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      ptr_r       <= '0;
      swp_wv_r    <= 1'b0;
      out_valid_r <= 1'b0;
      sel_r       <= SEL_INIT;
      lfsr_r      <= LFSR_SEED;
      thr_r       <= THR_RST;
      leader_r    <= LEADER_RST;
      fcs_r       <= '0;
      fcd_r       <= '0;
      sclr_r      <= 1'b0;
      decay_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      swp_wv_r    <= swp_wv_nxt;
      out_valid_r <= out_valid_nxt;
      sel_r       <= sel_nxt;
      lfsr_r      <= lfsr_nxt;
      fcs_r       <= fcs_nxt;
      fcd_r       <= fcd_nxt;
      sclr_r      <= sclr_nxt;
      decay_r     <= decay_nxt;
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_THR) thr_r <= pwdata[1:0];
        if (paddr[2] == REG_LEADER) leader_r <= pwdata[6:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    swp_wa_r   <= swp_wa_nxt;
    out_data_r <= out_data_nxt;
    dsig_r     <= dsig_nxt;
    if (acc) begin
      type_r <= in_data.req_type;
      hit_r  <= in_data.was_hit;
      set_r  <= SET_W'(in_data.set_index);
      way_r  <= WAY_W'(in_data.way_index);
      sig_r  <= sig_in;
      addr_r <= in_data.phys_addr;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == REG_LEADER) ? {25'd0, leader_r} : {30'd0, thr_r};

  `RRIP_SS_ASSERT(a_busy_stalls, (state_r == ST_CLR || state_r == ST_SWEEP) |-> in_stall, "input accepted during clear or sweep")
  `RRIP_SS_ASSERT(a_idle_no_write, (state_r == ST_IDLE) |-> (!row_we && !str_we), "memory write while idle")
  `RRIP_SS_ASSERT(a_result_from_exec, $rose(out_valid) |-> ($past(state_r) == ST_EXEC), "result not produced by execute step")
  `RRIP_SS_ASSERT(a_lfsr_nonzero, lfsr_r != 16'd0, "lfsr locked at zero")

endmodule
